>>> hdl/lrs_pkg.sv
`default_nettype none

package lrs_pkg;

    localparam int STEP_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int FRAC_MAX      = 24;
    localparam int RATIO_W       = FRAC_MAX + 1;

    // pi in Q.28
    localparam logic [29:0] PI_Q28 = 30'd843314857;

    typedef enum logic [1:0] {
        KIND_DIRECT,
        KIND_RAMP,
        KIND_COS,
        KIND_DECAY
    } kind_t;

    // what every stage carries besides its own working values
    typedef struct packed {
        kind_t       kind;
        logic        flag;
        logic [31:0] base;
        logic [31:0] rate;
    } meta_t;

    typedef struct packed {
        meta_t       meta;
        logic [31:0] num;
        logic [31:0] den;
    } div_in_t;

    typedef struct packed {
        meta_t              meta;
        logic [RATIO_W-1:0] ratio;
    } div_out_t;

    // exact reciprocal forms for any 32-bit operand
    function automatic logic [31:0] div3(input logic [31:0] x);
        logic [63:0] p;
        p = 64'(x) * 64'h00000000AAAAAAAB;
        return 32'(p >> 33);
    endfunction

    function automatic logic [31:0] div10(input logic [31:0] x);
        logic [63:0] p;
        p = 64'(x) * 64'h00000000CCCCCCCD;
        return 32'(p >> 35);
    endfunction

    function automatic logic [31:0] div100(input logic [31:0] x);
        logic [63:0] p;
        p = 64'(x) * 64'h0000000051EB851F;
        return 32'(p >> 37);
    endfunction

    // floor(3*r/10) for a remainder of ten
    function automatic logic [2:0] lo_tab(input logic [3:0] r);
        logic [2:0] v;
        case (r)
            4'd4, 4'd5, 4'd6: v = 3'd1;
            4'd7, 4'd8, 4'd9: v = 3'd2;
            default:          v = 3'd0;
        endcase
        return v;
    endfunction

    // floor(6*r/10) for a remainder of ten
    function automatic logic [2:0] hi_tab(input logic [3:0] r);
        logic [2:0] v;
        case (r)
            4'd2, 4'd3: v = 3'd1;
            4'd4:       v = 3'd2;
            4'd5, 4'd6: v = 3'd3;
            4'd7, 4'd8: v = 3'd4;
            4'd9:       v = 3'd5;
            default:    v = 3'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/lrs_div.sv
`default_nettype none

// restoring divider, one quotient bit per stage, result saturated at 1.0
module lrs_div #(
    parameter int FRAC_BITS = lrs_pkg::FRAC_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire lrs_pkg::div_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output lrs_pkg::div_out_t     out_data
);

    localparam int F = FRAC_BITS;

    logic [F-1:0]        v_reg;
    logic [F:0]          rdy;
    lrs_pkg::meta_t      meta_reg [F];
    logic [31:0]         rem_reg  [F];
    logic [31:0]         den_reg  [F];
    logic [F-1:0]        quo_reg  [F];
    logic [F-1:0]        sat_reg;

    lrs_pkg::meta_t      meta_in [F];
    logic [31:0]         rem_in  [F];
    logic [31:0]         den_in  [F];
    logic [F-1:0]        quo_in  [F];
    logic [F-1:0]        sat_in;
    logic [F-1:0]        val_in;

    assign rdy[F]   = out_ready;
    assign in_ready = rdy[0];

    genvar j;
    generate
        for (j = 0; j < F; j++)
        begin : g_stage
            logic [32:0]  t;
            logic         ge;
            logic [31:0]  rem_next;
            logic [F-1:0] quo_next;

            if (j == 0)
            begin : g_first
                assign meta_in[j] = in_data.meta;
                assign rem_in[j]  = in_data.num;
                assign den_in[j]  = in_data.den;
                assign quo_in[j]  = '0;
                assign sat_in[j]  = in_data.num >= in_data.den;
                assign val_in[j]  = in_valid;
            end
            else
            begin : g_rest
                assign meta_in[j] = meta_reg[j-1];
                assign rem_in[j]  = rem_reg[j-1];
                assign den_in[j]  = den_reg[j-1];
                assign quo_in[j]  = quo_reg[j-1];
                assign sat_in[j]  = sat_reg[j-1];
                assign val_in[j]  = v_reg[j-1];
            end

            assign rdy[j]   = !v_reg[j] || rdy[j+1];
            assign t        = {rem_in[j], 1'b0};
            assign ge       = t >= {1'b0, den_in[j]};
            assign rem_next = ge ? 32'(t - {1'b0, den_in[j]}) : t[31:0];
            assign quo_next = {quo_in[j][F-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[j] <= 1'b0;
                end
                else if (rdy[j])
                begin
                    v_reg[j] <= val_in[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[j] && val_in[j])
                begin
                    meta_reg[j] <= meta_in[j];
                    rem_reg[j]  <= rem_next;
                    den_reg[j]  <= den_in[j];
                    quo_reg[j]  <= quo_next;
                    sat_reg[j]  <= sat_in[j];
                end
            end
        end
    endgenerate

    assign out_valid     = v_reg[F-1];
    assign out_data.meta = meta_reg[F-1];
    assign out_data.ratio = sat_reg[F-1] ? (lrs_pkg::RATIO_W'(1) << F)
                                         : lrs_pkg::RATIO_W'(quo_reg[F-1]);

endmodule

`default_nettype wire

>>> hdl/lrs_post.sv
`default_nettype none

// scaling, cosine polynomial and one-cycle decay, seven register stages
module lrs_post #(
    parameter int FRAC_BITS = lrs_pkg::FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lrs_pkg::div_out_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lrs_pkg::meta_t         out_data
);

    localparam int F  = FRAC_BITS;
    localparam int NS = 7;

    typedef struct packed {
        lrs_pkg::meta_t              meta;
        logic [lrs_pkg::RATIO_W-1:0] ratio;
        logic [63:0]                 acc;
        logic [35:0]                 y;
        logic [17:0]                 aux;
        logic [17:0]                 zlo;
    } post_t;

    post_t        st_reg  [NS];
    post_t        st_next [NS];
    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;
    logic [NS-1:0] val_in;

    logic [29:0] x1;
    logic [31:0] t10;
    logic [31:0] qv;
    logic [35:0] z3;
    logic [35:0] z4;
    logic [1:0]  ra;
    logic [31:0] lowq;
    logic [63:0] pos5;
    logic [63:0] neg5;
    logic [63:0] f5;

    // stage 0: first product
    always_comb
    begin
        st_next[0].meta  = in_data.meta;
        st_next[0].ratio = in_data.ratio;
        st_next[0].acc   = '0;
        st_next[0].y     = '0;
        st_next[0].aux   = '0;
        st_next[0].zlo   = '0;
        case (in_data.meta.kind)
            lrs_pkg::KIND_RAMP:
                st_next[0].acc = 64'(in_data.meta.base) * 64'(in_data.ratio);
            lrs_pkg::KIND_COS:
                st_next[0].acc = 64'(lrs_pkg::PI_Q28) * 64'(in_data.ratio);
            lrs_pkg::KIND_DECAY:
                st_next[0].acc = 64'(32'(in_data.ratio) * 32'd9) * 64'h00000000CCCCCCCD;
            default:
                st_next[0].acc = '0;
        endcase
    end

    // stage 1: ramp done, x squared, decay factor times base
    always_comb
    begin
        st_next[1] = st_reg[0];
        x1  = 30'(st_reg[0].acc >> F);
        t10 = 32'(st_reg[0].acc >> 35);
        qv  = (32'd1 << F) - t10;
        case (st_reg[0].meta.kind)
            lrs_pkg::KIND_RAMP:
                st_next[1].meta.rate = 32'(st_reg[0].acc >> F);
            lrs_pkg::KIND_COS:
                st_next[1].acc = 64'(x1) * 64'(x1);
            lrs_pkg::KIND_DECAY:
                st_next[1].acc = 64'(st_reg[0].meta.base) * 64'(qv);
            default:
                st_next[1].acc = st_reg[0].acc;
        endcase
    end

    // stage 2: y and y2, decay rate done
    always_comb
    begin
        st_next[2] = st_reg[1];
        case (st_reg[1].meta.kind)
            lrs_pkg::KIND_COS:
            begin
                st_next[2].y   = 36'(st_reg[1].acc >> 24);
                st_next[2].acc = 64'(st_next[2].y[35:16]) * 64'(st_next[2].y[35:16]);
            end
            lrs_pkg::KIND_DECAY:
                st_next[2].meta.rate = 32'(st_reg[1].acc >> F);
            default:
                st_next[2].acc = st_reg[1].acc;
        endcase
    end

    // stage 3: y2/16 split in two chunks, upper chunk over three
    always_comb
    begin
        st_next[3] = st_reg[2];
        z3 = 36'(st_reg[2].acc >> 4);
        st_next[3].aux = 18'(lrs_pkg::div3(32'(z3[35:18])));
        st_next[3].zlo = z3[17:0];
    end

    // stage 4: lower chunk with carried remainder, y2/48
    always_comb
    begin
        st_next[4] = st_reg[3];
        z4   = 36'(st_reg[3].acc >> 4);
        ra   = 2'(z4[35:18] - 18'(st_reg[3].aux * 18'd3));
        lowq = lrs_pkg::div3(32'({ra, st_reg[3].zlo}));
        if (st_reg[3].meta.kind == lrs_pkg::KIND_COS)
        begin
            st_next[4].acc = 64'({st_reg[3].aux, 18'd0}) + 64'(lowq);
        end
    end

    // stage 5: f = 1 + y2/48 - y/4, clamped to [0, 1]
    always_comb
    begin
        st_next[5] = st_reg[4];
        pos5 = (64'd1 << 32) + st_reg[4].acc;
        neg5 = 64'(st_reg[4].y >> 2);
        f5   = (pos5 > neg5) ? (pos5 - neg5) : 64'd0;
        if (f5 > (64'd1 << 32))
        begin
            f5 = 64'd1 << 32;
        end
        if (st_reg[4].meta.kind == lrs_pkg::KIND_COS)
        begin
            st_next[5].acc = f5;
        end
    end

    // stage 6: base times f
    always_comb
    begin
        st_next[6] = st_reg[5];
        if (st_reg[5].meta.kind == lrs_pkg::KIND_COS)
        begin
            if (st_reg[5].acc[32])
            begin
                st_next[6].meta.rate = st_reg[5].meta.base;
            end
            else
            begin
                st_next[6].meta.rate =
                    32'((64'(st_reg[5].meta.base) * 64'(st_reg[5].acc[31:0])) >> 32);
            end
        end
    end

    assign rdy[NS]   = out_ready;
    assign in_ready  = rdy[0];
    assign val_in[0] = in_valid;

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_stage
            if (k > 0)
            begin : g_val
                assign val_in[k] = v_reg[k-1];
            end

            assign rdy[k] = !v_reg[k] || rdy[k+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (rdy[k])
                begin
                    v_reg[k] <= val_in[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k] && val_in[k])
                begin
                    st_reg[k] <= st_next[k];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NS-1];
    assign out_data  = st_reg[NS-1].meta;

endmodule

`default_nettype wire

>>> hdl/learning_rate_schedule_top.sv
`default_nettype none

// pipeline: select stage, one divider stage per fraction bit, seven post stages
//   with the multipliers; throughput: one step per cycle while the output is not
//   stalled and input not held off, set by the fully pipelined divider and multipliers
// reset: registers return to their reset values, pipeline empties; input is held off
//   after reset and after every register write while derived values settle
module learning_rate_schedule_top #(
    parameter int STEP_BITS = lrs_pkg::STEP_BITS_DEF,
    parameter int FRAC_BITS = lrs_pkg::FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] step_index
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] rate_out
    output logic             m_axis_tuser,   // [0] divisor_zero
    input  wire logic        cfg_wen,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata
);

    localparam int SB = STEP_BITS;

    localparam logic [2:0] REG_BASE   = 3'd0;
    localparam logic [2:0] REG_TOTAL  = 3'd1;
    localparam logic [2:0] REG_WARMUP = 3'd2;
    localparam logic [2:0] REG_MODE   = 3'd3;

    localparam logic [2:0] MODE_CONST    = 3'd0;
    localparam logic [2:0] MODE_WARMUP   = 3'd1;
    localparam logic [2:0] MODE_COSINE   = 3'd2;
    localparam logic [2:0] MODE_ONECYCLE = 3'd3;
    localparam logic [2:0] MODE_STEP     = 3'd4;

    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    logic [31:0] base_reg;
    logic [31:0] total_reg;
    logic [15:0] warmup_reg;
    logic [2:0]  mode_reg;
    logic [1:0]  settle_reg;

    // derived values, registered from the configuration; lo_reg and hi_reg from m10_reg and m_reg
    logic [SB-1:0] m_reg;
    logic [SB-1:0] w_reg;
    logic [31:0]   m10_reg;
    logic [31:0]   b10_reg;
    logic [31:0]   b100_reg;
    logic [SB-1:0] lo_reg;
    logic [SB-1:0] hi_reg;

    logic [SB-1:0] m_next;
    logic [47:0]   wprod;
    logic [3:0]    mrem;

    lrs_pkg::div_in_t sel_reg;
    lrs_pkg::div_in_t sel_next;
    logic             sel_valid_reg;
    logic             sel_ready;
    logic [SB-1:0]    s;

    logic              div_in_ready;
    logic              div_out_valid;
    lrs_pkg::div_out_t div_out;
    logic              post_in_ready;
    lrs_pkg::meta_t    post_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= 32'd1288490;
            total_reg  <= 32'd10000;
            warmup_reg <= 16'd6554;
            mode_reg   <= MODE_COSINE;
            settle_reg <= SETTLE_CYCLES;
        end
        else
        begin
            if (cfg_wen)
            begin
                settle_reg <= SETTLE_CYCLES;
                case (cfg_addr)
                    REG_BASE:   base_reg   <= cfg_wdata;
                    REG_TOTAL:  total_reg  <= cfg_wdata;
                    REG_WARMUP: warmup_reg <= cfg_wdata[15:0];
                    REG_MODE:   mode_reg   <= cfg_wdata[2:0];
                    default:    ;
                endcase
            end
            else if (settle_reg != 2'd0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    assign m_next = total_reg[SB-1:0];
    assign wprod  = 48'(warmup_reg) * 48'(m_next);
    assign mrem   = 4'(32'(m_reg) - 32'(m10_reg * 32'd10));

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        w_reg    <= SB'(wprod >> 16);
        m10_reg  <= lrs_pkg::div10(32'(m_next));
        b10_reg  <= lrs_pkg::div10(base_reg);
        b100_reg <= lrs_pkg::div100(base_reg);
        lo_reg   <= SB'(32'(m10_reg * 32'd3) + 32'(lrs_pkg::lo_tab(mrem)));
        hi_reg   <= SB'(32'(m10_reg * 32'd6) + 32'(lrs_pkg::hi_tab(mrem)));
    end

    // schedule select: which ratio to form and what to do with it
    assign s = s_axis_tdata[SB-1:0];

    always_comb
    begin
        sel_next.meta.kind = lrs_pkg::KIND_DIRECT;
        sel_next.meta.flag = 1'b0;
        sel_next.meta.base = base_reg;
        sel_next.meta.rate = base_reg;
        sel_next.num       = 32'(s);
        sel_next.den       = 32'(w_reg);
        case (mode_reg)
            MODE_WARMUP:
            begin
                if (s < w_reg)
                begin
                    sel_next.meta.kind = lrs_pkg::KIND_RAMP;
                end
            end
            MODE_COSINE:
            begin
                if (s < w_reg)
                begin
                    sel_next.meta.kind = lrs_pkg::KIND_RAMP;
                end
                else if (m_reg == w_reg)
                begin
                    sel_next.meta.flag = 1'b1;
                end
                else
                begin
                    sel_next.meta.kind = lrs_pkg::KIND_COS;
                    sel_next.num       = 32'(s - w_reg);
                    sel_next.den       = 32'(m_reg - w_reg);
                end
            end
            MODE_ONECYCLE:
            begin
                sel_next.den = 32'(lo_reg);
                if (s < lo_reg)
                begin
                    sel_next.meta.kind = lrs_pkg::KIND_RAMP;
                end
                else if (m_reg == lo_reg)
                begin
                    sel_next.meta.flag = 1'b1;
                end
                else
                begin
                    sel_next.meta.kind = lrs_pkg::KIND_DECAY;
                    sel_next.num       = 32'(s - lo_reg);
                    sel_next.den       = 32'(m_reg - lo_reg);
                end
            end
            MODE_STEP:
            begin
                if (s > hi_reg)
                begin
                    sel_next.meta.rate = b100_reg;
                end
                else if (s > lo_reg)
                begin
                    sel_next.meta.rate = b10_reg;
                end
            end
            default:
                sel_next.meta.rate = base_reg;
        endcase
    end

    assign sel_ready     = !sel_valid_reg || div_in_ready;
    assign s_axis_tready = sel_ready && (settle_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
        end
        else if (sel_ready)
        begin
            sel_valid_reg <= s_axis_tvalid && s_axis_tready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            sel_reg <= sel_next;
        end
    end

    lrs_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sel_valid_reg),
        .in_ready  (div_in_ready),
        .in_data   (sel_reg),
        .out_valid (div_out_valid),
        .out_ready (post_in_ready),
        .out_data  (div_out)
    );

    lrs_post #(
        .FRAC_BITS (FRAC_BITS)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_out_valid),
        .in_ready  (post_in_ready),
        .in_data   (div_out),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (post_out)
    );

    assign m_axis_tdata = post_out.rate;
    assign m_axis_tuser = post_out.flag;

    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wen |=> !s_axis_tready)
        else $error("input accepted right after a register write");

    a_flag_only_direct: assert property (@(posedge clk) disable iff (!rst_n)
        sel_valid_reg && sel_reg.meta.flag |-> sel_reg.meta.kind == lrs_pkg::KIND_DIRECT)
        else $error("zero divisor item routed through the divider");

    a_flag_gives_base: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == base_reg)
        else $error("zero divisor result differs from base rate");

    a_const_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && mode_reg == MODE_CONST |-> m_axis_tdata == base_reg && !m_axis_tuser)
        else $error("constant schedule result differs from base rate");

    a_rate_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata <= base_reg)
        else $error("rate above base rate");

endmodule

`default_nettype wire
